### sv/sag_pkg.sv
// Shared types and constants for the Sobel average gradient block.
// Used by the line store RAM, the square root and divider units and the top level.
package sag_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 12;
  localparam int PIX_W      = 8;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int MAG_W      = 11;
  localparam int SQ_W       = 21;
  localparam int SUM_W      = 34;
  localparam int AREA_W     = COL_W + ROW_W + 1;
  localparam int AVG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd480;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN,
    ST_GRAD,
    ST_SQ,
    ST_SQRT,
    ST_ACC,
    ST_MULT,
    ST_DIVST,
    ST_DIV,
    ST_OUT
  } sag_state_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [LINE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

### sv/sag_line_ram.sv
// Line store for the two previous rows: one entry per column holds {top, middle}.
// Synchronous memory with registered read data; depends on sag_pkg.
module sag_line_ram (
  input  logic                         clk,
  input  sag_pkg::ram_wr_t             wr,
  input  logic                         rd_en,
  input  logic [sag_pkg::COL_W-1:0]    rd_addr,
  output logic [sag_pkg::LINE_W-1:0]   rd_data
);
  import sag_pkg::*;

  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/sag_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on sag_pkg for widths.
module sag_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sag_pkg::SQ_W-1:0]   value,
  output logic                       done,
  output logic [sag_pkg::MAG_W-1:0]  root
);
  import sag_pkg::*;

  localparam logic [SQ_W:0] BIT_TOP = (SQ_W+1)'(1) << (2 * ((SQ_W - 1) / 2));

  logic [SQ_W:0] v_r, v_nxt;
  logic [SQ_W:0] root_r, root_nxt;
  logic [SQ_W:0] bit_r, bit_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SQ_W:0] trial;

  always_comb begin
    trial    = root_r + bit_r;
    v_nxt    = v_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = {1'b0, value};
      root_nxt = '0;
      bit_nxt  = BIT_TOP;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt    = v_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == (SQ_W+1)'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r    <= v_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign done = done_r;
  assign root = root_r[MAG_W-1:0];

endmodule

### sv/sag_div.sv
// Restoring divider, one quotient bit per cycle, for the frame average.
// Depends on sag_pkg for widths.
module sag_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sag_pkg::SUM_W-1:0]    dividend,
  input  logic [sag_pkg::AREA_W-1:0]   divisor,
  output logic                         done,
  output logic [sag_pkg::AVG_W-1:0]    quotient
);
  import sag_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [AREA_W-1:0] rem_r, rem_nxt;
  logic [AREA_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [AREA_W:0]   rem_sh;
  logic              q_bit;

  always_comb begin
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    q_bit    = rem_sh >= {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = q_bit ? AREA_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[AREA_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], q_bit};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[AVG_W-1:0];

endmodule

### sv/sobel_average_gradient.sv
// Sobel average gradient, top level: a border pixel beat passes the states IDLE, WIN, GRAD
// and ACC; an interior one adds SQ, and in mode 1 also the 11-step square root and its
// done flag. The last pixel of a frame adds the multiply, the 34-step divider and the
// output load, which waits while an earlier result still waits at the output.
// The result sits in an output register, so a waiting result stalls the input only then.
// Reset (rst_n, synchronous, active low) clears counters, sum, window and control and
// loads width 640, height 480, Euclidean mode; the line store is not cleared.
module sobel_average_gradient (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sag_pkg::SIZE_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sag_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sag_pkg::AVG_W-1:0]      out_avg_gradient
);
  import sag_pkg::*;

  // Configuration registers.
  logic [SIZE_W-1:0] width_r, height_r;
  logic              mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mode_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_MODE:   mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sizes as used: zero counts as one, anything above the maximum as the maximum.
  logic [SIZE_W-1:0] w_use, h_use;
  always_comb begin
    priority if (width_r == '0) w_use = SIZE_W'(1);
    else if (width_r > SIZE_W'(MAX_WIDTH)) w_use = SIZE_W'(MAX_WIDTH);
    else w_use = width_r;
    priority if (height_r == '0) h_use = SIZE_W'(1);
    else if (height_r > SIZE_W'(MAX_HEIGHT)) h_use = SIZE_W'(MAX_HEIGHT);
    else h_use = height_r;
  end

  sag_state_t state_r, state_nxt;

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [PIX_W-1:0]  px_r;
  logic [PIX_W-1:0]  win_r [9];
  logic              interior_r, frame_end_r;
  logic [9:0]        ax_r, ay_r;
  logic [MAG_W-1:0]  mag_r;
  logic [SUM_W-1:0]  sum_r;
  logic [AREA_W-1:0] area_r;
  logic [AVG_W-1:0]  out_r;
  logic              out_valid_r;

  logic              accept;
  logic [LINE_W-1:0] line_rd;
  ram_wr_t           line_wr;
  unit_ctl_t         sqrt_ctl, div_ctl;
  logic [MAG_W-1:0]  sqrt_root;
  logic [AVG_W-1:0]  div_quo;
  logic [SQ_W-1:0]   sq_val;
  logic              row_end, frame_end;
  logic              out_load;

  assign accept = in_valid && !in_stall;

  // The line store is read at the current column when the beat is taken and
  // written back in the following cycle, before any later beat can read it.
  sag_line_ram u_line (
    .clk     (clk),
    .wr      (line_wr),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (line_rd)
  );

  assign sq_val = SQ_W'(ax_r * ax_r) + SQ_W'(ay_r * ay_r);

  sag_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_ctl.start),
    .value (sq_val),
    .done  (sqrt_ctl.done),
    .root  (sqrt_root)
  );

  sag_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_ctl.start),
    .dividend (sum_r),
    .divisor  (area_r),
    .done     (div_ctl.done),
    .quotient (div_quo)
  );

  // Row and frame end tests against the sizes in force now.
  assign row_end   = ({1'b0, col_r} + SIZE_W'(1)) >= w_use;
  assign frame_end = row_end && (({1'b0, row_r} + SIZE_W'(1)) >= h_use);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_WIN;
      ST_WIN:   state_nxt = ST_GRAD;
      ST_GRAD:  state_nxt = interior_r ? ST_SQ : ST_ACC;
      ST_SQ:    state_nxt = mode_r ? ST_SQRT : ST_ACC;
      ST_SQRT:  if (sqrt_ctl.done) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = frame_end_r ? ST_MULT : ST_IDLE;
      ST_MULT:  state_nxt = ST_DIVST;
      ST_DIVST: state_nxt = ST_DIV;
      ST_DIV:   if (div_ctl.done) state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall       = 1'b1;
    line_wr.en     = 1'b0;
    line_wr.addr   = col_r;
    line_wr.data   = {line_rd[PIX_W-1:0], px_r};
    sqrt_ctl.start = 1'b0;
    div_ctl.start  = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_WIN:   line_wr.en = 1'b1;
      ST_SQ:    sqrt_ctl.start = mode_r;
      ST_DIVST: div_ctl.start = 1'b1;
      ST_OUT:   out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // Sobel gradients from the window; column 0 is the oldest (left) column.
  logic [9:0]  g_left, g_right, g_top, g_bot;
  logic [10:0] gx, gy;
  always_comb begin
    g_left  = 10'(win_r[0]) + {1'b0, win_r[3], 1'b0} + 10'(win_r[6]);
    g_right = 10'(win_r[2]) + {1'b0, win_r[5], 1'b0} + 10'(win_r[8]);
    g_top   = 10'(win_r[0]) + {1'b0, win_r[1], 1'b0} + 10'(win_r[2]);
    g_bot   = 10'(win_r[6]) + {1'b0, win_r[7], 1'b0} + 10'(win_r[8]);
    gx      = {1'b0, g_left} - {1'b0, g_right};
    gy      = {1'b0, g_top} - {1'b0, g_bot};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_WIN) begin
        // Shift the window left and bring in the new column.
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]   <= win_r[k*3+1];
          win_r[k*3+1] <= win_r[k*3+2];
        end
        win_r[2] <= line_rd[LINE_W-1:PIX_W];
        win_r[5] <= line_rd[PIX_W-1:0];
        win_r[8] <= px_r;
        if (frame_end) begin
          col_r <= '0;
          row_r <= '0;
        end else if (row_end) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (state_r == ST_ACC && interior_r) begin
        sum_r <= sum_r + SUM_W'(mag_r);
      end
      // The divider has its own copy of the sum, so the sum starts the next frame clear.
      if (div_ctl.start) begin
        sum_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_pixel;
    end
    if (state_r == ST_WIN) begin
      interior_r  <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      frame_end_r <= frame_end;
    end
    if (state_r == ST_GRAD) begin
      ax_r <= gx[10] ? 10'(-gx) : gx[9:0];
      ay_r <= gy[10] ? 10'(-gy) : gy[9:0];
    end
    if (state_r == ST_SQ && !mode_r) begin
      mag_r <= MAG_W'(ax_r) + MAG_W'(ay_r);
    end
    if (sqrt_ctl.done) begin
      mag_r <= sqrt_root;
    end
    if (state_r == ST_MULT) begin
      area_r <= AREA_W'(w_use * h_use);
    end
    if (out_load) begin
      out_r <= div_quo;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_avg_gradient = out_r;

  a_accept_to_win: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_WIN)
    else $error("accepted beat did not start the line store update");

  a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_ctl.done |-> state_r == ST_SQRT)
    else $error("square root finished outside its wait state");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.done |-> state_r == ST_DIV)
    else $error("divider finished outside its wait state");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared without a frame end");

endmodule

### dv/testbench.sv
// Testbench for sobel_average_gradient: drives pixel frames of many sizes and both
// magnitude modes, predicts each frame's average gradient and checks every result beat.
// Depends on sag_pkg and the sobel_average_gradient RTL.
module testbench;
  import sag_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [AVG_W-1:0]     out_avg_gradient;

  sobel_average_gradient u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_avg_gradient (out_avg_gradient)
  );

  // The drain wait covers one Euclidean pixel plus the end-of-frame multiply, divide
  // and output load, with some margin.
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 3000000;

  // Expected frame averages, oldest first.
  logic [AVG_W-1:0] avg_expected[$];
  int               mismatches;
  int               failures;
  bit               idling_on;
  int               hold_off_left;

  // Shadow copy of the block's registers and frame state.
  logic [SIZE_W-1:0] shadow_width;
  logic [SIZE_W-1:0] shadow_height;
  logic              shadow_mode;
  logic [PIX_W-1:0]  rows_above[0:2*MAX_WIDTH-1];
  logic [PIX_W-1:0]  win[0:2][0:2];   // win[row][col], col 0 is the oldest column
  int unsigned       col_pos;
  int unsigned       row_pos;
  logic [SUM_W-1:0]  grad_sum;

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  function automatic int unsigned floor_root(int unsigned v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = 2048;
    // Largest lo with lo*lo <= v.
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // Advances the frame state by one accepted pixel and queues the average when the
  // pixel closes the frame.
  function automatic void sobel_track(logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    int gx;
    int gy;
    int unsigned ax;
    int unsigned ay;
    int unsigned mag;
    longint unsigned area;
    w = clamp_dim(shadow_width, MAX_WIDTH);
    h = clamp_dim(shadow_height, MAX_HEIGHT);
    top = 0;
    mid = 0;
    if (col_pos < MAX_WIDTH) begin
      top = rows_above[col_pos];
      mid = rows_above[MAX_WIDTH + col_pos];
      rows_above[col_pos] = mid;
      rows_above[MAX_WIDTH + col_pos] = px;
    end
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]))
         - (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]));
      gy = (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]))
         - (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]));
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      mag = shadow_mode ? floor_root(ax * ax + ay * ay) : ax + ay;
      grad_sum = grad_sum + mag;
    end
    if (col_pos + 1 >= w) begin
      if (row_pos + 1 >= h) begin
        area = longint'(w) * longint'(h);
        avg_expected.push_back(AVG_W'(longint'(grad_sum) / area));
        col_pos = 0;
        row_pos = 0;
        grad_sum = 0;
      end else begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 11'h7FF;
      end
    end else begin
      col_pos = (col_pos + 1) & 11'h7FF;
    end
  endfunction

  // Clock and a single reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter that ends a hung run.
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("FAIL sobel_average_gradient");
        $finish;
      end
    end
  end

  // Receiver side: random stall bursts, plus a long hold-off when a test asks for it.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && idling_on && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 8);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else if (stall_left > 0 && idling_on) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = 0;
      end
    end
  end

  // Result checker. Signals are read at the edge before the block's own updates land,
  // so each sample is the value that the handshake saw.
  always @(posedge clk) begin
    logic [AVG_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (avg_expected.size() == 0) begin
        failures++;
        if (mismatches < 10)
          $display("unexpected result beat: avg_gradient=%0d", out_avg_gradient);
        mismatches++;
      end else begin
        want = avg_expected.pop_front();
        if (out_avg_gradient !== want) begin
          failures++;
          if (mismatches < 10)
            $display("avg_gradient mismatch: expected %0d, got %0d", want, out_avg_gradient);
          mismatches++;
        end
      end
    end
  end

  // Offers one pixel beat and waits for it to be taken; a random gap may follow.
  task automatic push_pixel(input logic [PIX_W-1:0] px);
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    sobel_track(px);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_pixel <= PIX_W'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected frame result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic m);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_wdata <= SIZE_W'(m);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_width  = w;
    shadow_height = h;
    shadow_mode   = m;
  endtask

  // One 3x3 frame with a fixed picture: 0 vertical edge, 1 horizontal edge,
  // 2 checkerboard, 3 flat white, 4 flat black.
  task automatic send_pattern(input int pic);
    logic [PIX_W-1:0] px;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        case (pic)
          0: px = (c == 0) ? 8'hFF : 8'h00;
          1: px = (r == 2) ? 8'hFF : 8'h00;
          2: px = ((r + c) % 2) ? 8'hFF : 8'h00;
          3: px = 8'hFF;
          default: px = 8'h00;
        endcase
        push_pixel(px);
      end
    end
  endtask

  // A given number of pixels, usually one frame in the current size, random or with strong edges.
  task automatic send_frame(input int unsigned count);
    bit harsh;
    harsh = ($urandom_range(0, 2) == 0);
    for (int unsigned i = 0; i < count; i++)
      push_pixel(harsh ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : PIX_W'($urandom));
  endtask

  // Largest gradients in both modes, and flat pictures that give zero.
  task automatic test_gradient_extremes();
    for (int m = 0; m < 2; m++) begin
      set_frame(12'd3, 12'd3, m[0]);
      for (int pic = 0; pic < 5; pic++) send_pattern(pic);
    end
  endtask

  // Sizes of zero, frames too small for an interior, and sizes past the maximum.
  // An oversized frame is cut short by shrinking the size, which closes it on the
  // next beat.
  task automatic test_size_limits();
    set_frame(12'd0, 12'd0, 1'b0);
    repeat (3) push_pixel(PIX_W'($urandom));
    set_frame(12'd2, 12'd2, 1'b1);
    send_frame(4);
    set_frame(12'd4095, 12'd1, 1'b1);
    send_frame(64);
    set_frame(12'd1, 12'd1, 1'b1);
    push_pixel(PIX_W'($urandom));
    set_frame(12'd1, 12'd4095, 1'b0);
    send_frame(64);
    set_frame(12'd1, 12'd1, 1'b0);
    push_pixel(PIX_W'($urandom));
    set_frame(12'd40, 12'd3, 1'b0);
    send_frame(120);
  endtask

  // One-pixel and then 3x2 frames under a long receiver hold-off, so results back up and the
  // block has to stall its input.
  task automatic test_backpressure();
    set_frame(12'd1, 12'd1, 1'b0);
    hold_off_left = 400;
    repeat (30) push_pixel(PIX_W'($urandom));
    set_frame(12'd3, 12'd2, 1'b1);
    hold_off_left = 300;
    repeat (8) send_frame(6);
  endtask

  // Random frame sizes and modes, with a full pause every so often.
  task automatic test_random_frames(input int unsigned budget);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    sent = 0;
    while (sent < budget) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      set_frame(SIZE_W'(w), SIZE_W'(h), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3)) begin
        send_frame(w * h);
        sent += w * h;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_WIDTH;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_pixel      = '0;
    mismatches    = 0;
    failures      = 0;
    idling_on     = 1'b1;
    hold_off_left = 0;
    shadow_width  = WIDTH_RST;
    shadow_height = HEIGHT_RST;
    shadow_mode   = 1'b1;
    col_pos       = 0;
    row_pos       = 0;
    grad_sum      = '0;
    for (int i = 0; i < 2 * MAX_WIDTH; i++) rows_above[i] = '0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_gradient_extremes();
    test_size_limits();
    test_backpressure();
    test_random_frames(500);
    // The last stretch runs with no idling on either side.
    drain_results();
    idling_on = 1'b0;
    test_random_frames(150);

    in_valid <= 1'b0;
    for (int i = 0; i < 200000 && avg_expected.size() != 0; i++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (avg_expected.size() != 0) begin
      failures++;
      $display("%0d expected results never arrived", avg_expected.size());
    end
    if (failures == 0) begin
      $display("PASS sobel_average_gradient");
    end else begin
      $display("FAIL sobel_average_gradient");
    end
    $finish;
  end

endmodule
